// ===== design/ffha_pkg.sv =====
// First-fit heap allocator: shared constants for field widths, chunk kinds,
// command and status codes. No dependencies.
`default_nettype none

package ffha_pkg;

    // Port field widths
    localparam int CMD_W  = 1;
    localparam int REQ_W  = 12;
    localparam int OFF_W  = 12;
    localparam int STAT_W = 2;

    // Rounded request: up to 4096, one bit wider than the request field
    localparam int NEED_W = REQ_W + 1;

    // Chunk header geometry
    localparam int HDR_BYTES   = 8;
    localparam int FIRST_HDR   = 8;
    localparam int ALIGN_MASK  = 15;

    // Chunk kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FREE = 2'd1;
    localparam logic [1:0] KIND_USED = 2'd2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Result status
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_FIT   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_FREE = 2'd2;

endpackage

`default_nettype wire

// ===== design/ffha_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/first_fit_heap_allocator_core.sv =====
// First-fit boundary-tag heap allocator, top level.
// Depends on ffha_pkg (constants) and ffha_ram (header tag memory).
//
//  channel | handshake         | fields                                     | dir
//  --------+-------------------+--------------------------------------------+----
//  s_      | s_valid / s_ready | s_command, s_request_size, s_block_offset  | in
//  m_      | m_valid / m_ready | m_status, m_payload_offset, m_free_bytes   | out
//
// After reset a clearing pass writes every slot of the tag memory in turn; s_ready is low.
// Allocate: a walk over the chunk headers (one tag read per cycle), plus a split step when needed.
// Free of a used chunk: serial reads of the chunk, its previous and next neighbors and the
// chunk after the merge; a rejected free ends after the offset check or the header read.
// One command is in flight at a time; the result waits in the output register, and the
// sequencer holds in its final state while an earlier result is still not taken.
`default_nettype none

module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ffha_pkg::CMD_W-1:0]    s_command,
    input  wire logic [ffha_pkg::REQ_W-1:0]    s_request_size,
    input  wire logic [ffha_pkg::OFF_W-1:0]    s_block_offset,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [ffha_pkg::STAT_W-1:0]   m_status,
    output logic      [ffha_pkg::OFF_W-1:0]    m_payload_offset,
    output logic      [ffha_pkg::OFF_W-1:0]    m_free_bytes
);

    import ffha_pkg::*;

    // Geometry
    localparam int DEPTH = HEAP_BYTES / HDR_BYTES;
    localparam int IW    = $clog2(DEPTH);
    localparam int AW    = $clog2(HEAP_BYTES);
    localparam int SW    = AW;
    localparam int WW    = ((AW > NEED_W) ? AW : NEED_W) + 2;
    localparam int TAG_W = 2 + 2 * SW;

    localparam logic [WW-1:0] HEAP_W  = WW'(HEAP_BYTES);
    localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
    localparam logic [WW-1:0] HDR_W   = WW'(HDR_BYTES);
    localparam logic [WW-1:0] FIRST_W = WW'(FIRST_HDR);
    localparam logic [WW-1:0] ALIGN_W = WW'(ALIGN_MASK);
    localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
    localparam logic [IW-1:0] FIRST_IDX = IW'(FIRST_HDR / HDR_BYTES);
    localparam logic [TAG_W-1:0] INIT_TAG =
        {KIND_FREE, SW'(HEAP_BYTES - FIRST_HDR - HDR_BYTES), SW'(0)};

    // Sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_A_USED = 4'd3;
    localparam logic [3:0] S_A_NEXT = 4'd4;
    localparam logic [3:0] S_F_HEAD = 4'd5;
    localparam logic [3:0] S_F_PREV = 4'd6;
    localparam logic [3:0] S_F_NEXT = 4'd7;
    localparam logic [3:0] S_F_WR   = 4'd8;
    localparam logic [3:0] S_F_N2   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // Header offset lies inside the tag memory
    function automatic logic slot_ok(input logic [WW-1:0] x);
        slot_ok = (x < HEAP_W) && ((x >> 3) < DEPTH_W);
    endfunction

    function automatic logic [IW-1:0] idx(input logic [WW-1:0] x);
        idx = x[IW+2:3];
    endfunction

    function automatic logic [TAG_W-1:0] mk_tag(input logic [1:0] k,
                                                input logic [WW-1:0] sz,
                                                input logic [WW-1:0] pv);
        mk_tag = {k, sz[SW-1:0], pv[SW-1:0]};
    endfunction

    // Registers
    logic [3:0]        state_reg, state_next;
    logic [IW-1:0]     clr_idx_reg, clr_idx_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [AW-1:0]     h_reg, h_next;
    logic [AW-1:0]     n_reg, n_next;
    logic [SW-1:0]     size_reg, size_next;
    logic [SW-1:0]     prev_reg, prev_next;
    logic [AW-1:0]     free_total_reg, free_total_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [OFF_W-1:0]  res_poff_reg, res_poff_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [OFF_W-1:0]  m_poff_reg, m_poff_next;
    logic [OFF_W-1:0]  m_free_reg, m_free_next;

    // Tag memory ports
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [TAG_W-1:0]  wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [TAG_W-1:0]  rd_data;

    ffha_ram #(
        .WIDTH (TAG_W),
        .DEPTH (DEPTH)
    ) u_tags (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read tag fields, widened for arithmetic
    logic [1:0]    rd_kind;
    logic [WW-1:0] rd_size_w, rd_prev_w;
    assign rd_kind   = rd_data[TAG_W-1 -: 2];
    assign rd_size_w = WW'(rd_data[2*SW-1 -: SW]);
    assign rd_prev_w = WW'(rd_data[SW-1:0]);

    logic [WW-1:0] h_w, n_w, size_w, prev_w, need_w, ft_w;
    assign h_w    = WW'(h_reg);
    assign n_w    = WW'(n_reg);
    assign size_w = WW'(size_reg);
    assign prev_w = WW'(prev_reg);
    assign need_w = WW'(need_reg);
    assign ft_w   = WW'(free_total_reg);

    // Command decode
    logic [WW-1:0] need_in, off_w, fh_w;
    assign need_in = (WW'(s_request_size) + ALIGN_W) & ~ALIGN_W;
    assign off_w   = WW'(s_block_offset);
    assign fh_w    = off_w - HDR_W;

    // Walk and merge address arithmetic
    logic [WW-1:0] walk_nx, split_r, ok_poff, back_w, merged_sz, nn_w, n2_w;
    assign walk_nx   = h_w + HDR_W + rd_size_w;
    assign split_r   = h_w + HDR_W + need_w;
    assign ok_poff   = h_w + HDR_W;
    assign back_w    = rd_prev_w + HDR_W;
    assign merged_sz = rd_size_w + HDR_W + size_w;
    assign n2_w      = h_w + HDR_W + size_w;

    logic prev_merge;
    assign prev_merge = (rd_kind == KIND_FREE);
    assign nn_w = prev_merge ? (n_w + HDR_W + merged_sz) : n2_w;

    assign s_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        need_next       = need_reg;
        h_next          = h_reg;
        n_next          = n_reg;
        size_next       = size_reg;
        prev_next       = prev_reg;
        free_total_next = free_total_reg;
        res_status_next = res_status_reg;
        res_poff_next   = res_poff_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_poff_next     = m_poff_reg;
        m_free_next     = m_free_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // Sweep the tag memory after reset
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = (clr_idx_reg == FIRST_IDX) ? INIT_TAG : '0;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + IW'(1);
                end
            end

            S_IDLE: begin
                res_poff_next = '0;
                if (s_valid) begin
                    if (s_command == CMD_ALLOC) begin
                        need_next = need_in[NEED_W-1:0];
                        if (ft_w < need_in) begin
                            res_status_next = STATUS_NO_FIT;
                            state_next      = S_DONE;
                        end else begin
                            h_next     = AW'(FIRST_W);
                            rd_en      = 1'b1;
                            rd_addr    = FIRST_IDX;
                            state_next = S_WALK;
                        end
                    end else if ((s_block_offset[2:0] != 3'd0) ||
                                 (off_w < FIRST_W + HDR_W) || !slot_ok(fh_w)) begin
                        res_status_next = STATUS_BAD_FREE;
                        state_next      = S_DONE;
                    end else begin
                        h_next     = AW'(fh_w);
                        rd_en      = 1'b1;
                        rd_addr    = idx(fh_w);
                        state_next = S_F_HEAD;
                    end
                end
            end

            // First-fit walk: one header per cycle
            S_WALK: begin
                if ((rd_kind == KIND_FREE) && (rd_size_w >= need_w)) begin
                    if (rd_size_w == need_w) begin
                        wr_en           = 1'b1;
                        wr_addr         = idx(h_w);
                        wr_data         = mk_tag(KIND_USED, rd_size_w, rd_prev_w);
                        free_total_next = AW'(ft_w - need_w);
                        res_status_next = STATUS_OK;
                        res_poff_next   = ok_poff[OFF_W-1:0];
                        state_next      = S_DONE;
                    end else if (!slot_ok(split_r)) begin
                        res_status_next = STATUS_NO_FIT;
                        state_next      = S_DONE;
                    end else begin
                        // remainder header becomes a free chunk
                        wr_en      = 1'b1;
                        wr_addr    = idx(split_r);
                        wr_data    = mk_tag(KIND_FREE, rd_size_w - need_w - HDR_W, need_w);
                        size_next  = rd_size_w[SW-1:0];
                        prev_next  = rd_prev_w[SW-1:0];
                        n_next     = AW'(walk_nx);
                        state_next = S_A_USED;
                    end
                end else if (!slot_ok(walk_nx)) begin
                    res_status_next = STATUS_NO_FIT;
                    state_next      = S_DONE;
                end else begin
                    h_next  = AW'(walk_nx);
                    rd_en   = 1'b1;
                    rd_addr = idx(walk_nx);
                end
            end

            // Split: mark the front part used, fetch the chunk after the remainder
            S_A_USED: begin
                wr_en           = 1'b1;
                wr_addr         = idx(h_w);
                wr_data         = mk_tag(KIND_USED, need_w, prev_w);
                free_total_next = AW'(ft_w - need_w - HDR_W);
                res_status_next = STATUS_OK;
                res_poff_next   = ok_poff[OFF_W-1:0];
                if (slot_ok(n_w)) begin
                    rd_en      = 1'b1;
                    rd_addr    = idx(n_w);
                    state_next = S_A_NEXT;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_A_NEXT: begin
                if (rd_kind != KIND_NONE) begin
                    wr_en   = 1'b1;
                    wr_addr = idx(n_w);
                    wr_data = mk_tag(rd_kind, rd_size_w, size_w - need_w - HDR_W);
                end
                state_next = S_DONE;
            end

            // Free: check the named chunk, look at the previous one (or else the next one)
            S_F_HEAD: begin
                if (rd_kind != KIND_USED) begin
                    res_status_next = STATUS_BAD_FREE;
                    state_next      = S_DONE;
                end else begin
                    free_total_next = AW'(ft_w + rd_size_w);
                    size_next       = rd_size_w[SW-1:0];
                    prev_next       = rd_prev_w[SW-1:0];
                    res_status_next = STATUS_OK;
                    if ((h_w != FIRST_W) && (back_w <= h_w - FIRST_W) &&
                        slot_ok(h_w - back_w)) begin
                        n_next     = AW'(h_w - back_w);
                        rd_en      = 1'b1;
                        rd_addr    = idx(h_w - back_w);
                        state_next = S_F_PREV;
                    end else if (slot_ok(walk_nx)) begin
                        n_next     = AW'(walk_nx);
                        rd_en      = 1'b1;
                        rd_addr    = idx(walk_nx);
                        state_next = S_F_NEXT;
                    end else begin
                        state_next = S_F_WR;
                    end
                end
            end

            // Merge into a free previous chunk, then fetch the next one
            S_F_PREV: begin
                if (prev_merge) begin
                    wr_en           = 1'b1;
                    wr_addr         = idx(h_w);
                    wr_data         = '0;
                    h_next          = n_reg;
                    size_next       = merged_sz[SW-1:0];
                    prev_next       = rd_prev_w[SW-1:0];
                    free_total_next = AW'(ft_w + HDR_W);
                end
                if (slot_ok(nn_w)) begin
                    n_next     = AW'(nn_w);
                    rd_en      = 1'b1;
                    rd_addr    = idx(nn_w);
                    state_next = S_F_NEXT;
                end else begin
                    state_next = S_F_WR;
                end
            end

            // Absorb a free next chunk
            S_F_NEXT: begin
                if (rd_kind == KIND_FREE) begin
                    wr_en           = 1'b1;
                    wr_addr         = idx(n_w);
                    wr_data         = '0;
                    size_next       = merged_sz[SW-1:0];
                    free_total_next = AW'(ft_w + HDR_W);
                end
                state_next = S_F_WR;
            end

            // Write the merged free chunk, fetch its successor
            S_F_WR: begin
                wr_en   = 1'b1;
                wr_addr = idx(h_w);
                wr_data = mk_tag(KIND_FREE, size_w, prev_w);
                if (slot_ok(n2_w)) begin
                    n_next     = AW'(n2_w);
                    rd_en      = 1'b1;
                    rd_addr    = idx(n2_w);
                    state_next = S_F_N2;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_F_N2: begin
                if (rd_kind != KIND_NONE) begin
                    wr_en   = 1'b1;
                    wr_addr = idx(n_w);
                    wr_data = mk_tag(rd_kind, rd_size_w, size_w);
                end
                state_next = S_DONE;
            end

            // Hand the result to the output register
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_poff_next   = res_poff_reg;
                    m_free_next   = ft_w[OFF_W-1:0];
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            free_total_reg <= AW'(HEAP_BYTES - FIRST_HDR - HDR_BYTES);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            free_total_reg <= free_total_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        need_reg       <= need_next;
        h_reg          <= h_next;
        n_reg          <= n_next;
        size_reg       <= size_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_poff_reg   <= res_poff_next;
        m_status_reg   <= m_status_next;
        m_poff_reg     <= m_poff_next;
        m_free_reg     <= m_free_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_payload_offset = m_poff_reg;
    assign m_free_bytes     = m_free_reg;

endmodule

`default_nettype wire
